// ===== src/rbma_pkg.sv =====
// ----------------------------------------------------------------------------
// rbma_pkg
// Shared types and constants of the ring buffer moving average unit.
// ----------------------------------------------------------------------------
package rbma_pkg;

  localparam int unsigned CAPACITY_DEF    = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed result field widths
  localparam int unsigned AVG_W   = 15;
  localparam int unsigned COUNT_W = 5;
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

endpackage

// ===== src/rbma_if.sv =====
// ----------------------------------------------------------------------------
// rbma_if
// Valid/ready channels of the ring buffer moving average unit.
// ----------------------------------------------------------------------------
interface rbma_in_if
  import rbma_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  op_e                           op;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rbma_out_if
  import rbma_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [AVG_W-1:0]              average;
  logic signed [SAMPLE_BITS-1:0] popped_value;
  logic [COUNT_W-1:0]            count;
  logic                          is_full;
  logic                          is_empty;
  logic                          underflow;

  modport source (output valid, output average, output popped_value, output count,
                  output is_full, output is_empty, output underflow, input ready);
  modport sink   (input valid, input average, input popped_value, input count,
                  input is_full, input is_empty, input underflow, output ready);
endinterface

// ===== src/rbma_div.sv =====
// ----------------------------------------------------------------------------
// rbma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rbma_div
  import rbma_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(DIVIDEND_W + 1);

  logic [ITER_W-1:0]     iter_q, iter_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvsr_q;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    fits  = trial >= {1'b0, dvsr_q};
    rem_d = fits ? DIVISOR_W'(trial - {1'b0, dvsr_q}) : DIVISOR_W'(trial);
    quo_d = {quo_q[DIVIDEND_W-2:0], fits};
  end

  always_comb begin
    iter_d = iter_q;
    done_d = 1'b0;
    if (start_i) begin
      iter_d = ITER_W'(DIVIDEND_W);
    end else if (iter_q != '0) begin
      iter_d = iter_q - 1'b1;
      done_d = (iter_q == ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
      done_q <= 1'b0;
    end else begin
      iter_q <= iter_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (iter_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/ring_buffer_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_moving_average_unit
// Ring of the last CAPACITY samples in a one-port synchronous memory, with a
// running sum and a truncated average over the held samples.
// ----------------------------------------------------------------------------
//   port    dir  word
//   in_i    in   op (push/pop), sample
//   out_o   out  average, popped_value, count, is_full, is_empty, underflow
//
// Per word: accept, update from the memory word, divider start, then the
// bit-serial divide and the result load; the divide is skipped when the ring
// is empty or the sum is not positive.
// Reset clears pointers, count and sum; a word read from an unheld slot is dropped.
// A stalled output holds its word; the next word is taken, then waits to load.
// ----------------------------------------------------------------------------
module ring_buffer_moving_average_unit
  import rbma_pkg::*;
#(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbma_in_if.sink    in_i,
  rbma_out_if.source out_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = SAMPLE_BITS + CNT_W;
  localparam int unsigned DVD_W = SUM_W - 1;
  localparam int unsigned QW    = (DVD_W > AVG_W) ? DVD_W : AVG_W;

  state_e state_q, state_d;

  logic [IDX_W-1:0]              oldest_q, oldest_d;
  logic [IDX_W-1:0]              wr_idx_q, wr_idx_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;

  op_e                           op_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic signed [SAMPLE_BITS-1:0] mem_q [CAPACITY];
  logic [IDX_W-1:0]              rd_addr;

  logic signed [SAMPLE_BITS-1:0] popped_q, popped_d;
  logic                          under_q, under_d;
  logic                          use_div_q;

  logic                          out_valid_q;
  logic [AVG_W-1:0]              out_avg_q;
  logic signed [SAMPLE_BITS-1:0] out_popped_q;
  logic [COUNT_W-1:0]            out_count_q;
  logic                          out_full_q;
  logic                          out_empty_q;
  logic                          out_under_q;

  logic                          in_ready;
  logic                          in_accept;
  logic                          mem_we;
  logic                          div_start;
  logic                          load_out;
  logic                          avg_nonzero;
  logic                          div_done;
  logic [DVD_W-1:0]              quotient;
  logic [QW-1:0]                 quo_ext;
  logic [AVG_W-1:0]              avg_val;
  logic                          is_full;
  logic                          old_valid;

  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(idx + 1'b1);
    return nxt;
  endfunction

  assign in_accept   = in_i.valid && in_ready;
  assign is_full     = (count_q == CNT_W'(CAPACITY));
  assign avg_nonzero = (count_q != '0) && (sum_q > 0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_i.valid) state_d = S_READ;
      S_READ:  state_d = S_START;
      S_START: state_d = avg_nonzero ? S_DIV : S_OUT;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_OUT:   if (!out_valid_q || out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready  = 1'b1;
      S_READ:  mem_we    = (op_q == OP_PUSH);
      S_START: div_start = avg_nonzero;
      S_DIV:   ;
      S_OUT:   load_out  = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;
  assign rd_addr    = (in_i.op == OP_PUSH) ? wr_idx_q : oldest_q;

  // ring update from the word read back from memory
  always_comb begin
    oldest_d  = oldest_q;
    wr_idx_d  = wr_idx_q;
    count_d   = count_q;
    sum_d     = sum_q;
    popped_d  = '0;
    under_d   = 1'b0;
    old_valid = is_full;
    if (op_q == OP_PUSH) begin
      // the slot under the write pointer holds a live sample only when full
      sum_d    = sum_q - (old_valid ? SUM_W'(rdata_q) : '0) + SUM_W'(sample_q);
      wr_idx_d = advance(wr_idx_q);
      if (is_full) begin
        oldest_d = advance(oldest_q);
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (count_q == '0) begin
      under_d = 1'b1;
    end else begin
      popped_d = rdata_q;
      sum_d    = sum_q - SUM_W'(rdata_q);
      oldest_d = advance(oldest_q);
      count_d  = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      oldest_q    <= '0;
      wr_idx_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_READ) begin
        oldest_q <= oldest_d;
        wr_idx_q <= wr_idx_d;
        count_q  <= count_d;
        sum_q    <= sum_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= sample_q;
    end
    if (in_accept) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= in_i.op;
      sample_q <= in_i.sample;
    end
    if (state_q == S_READ) begin
      popped_q <= popped_d;
      under_q  <= under_d;
    end
    if (state_q == S_START) begin
      use_div_q <= avg_nonzero;
    end
  end

  rbma_div #(
    .DIVIDEND_W (DVD_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q[DVD_W-1:0]),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // saturate the quotient into the average field, or give zero when the divide was skipped
  always_comb begin
    quo_ext = QW'(quotient);
    if (!use_div_q) begin
      avg_val = '0;
    end else if (quo_ext > QW'(AVG_MAX)) begin
      avg_val = AVG_MAX;
    end else begin
      avg_val = AVG_W'(quo_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q    <= avg_val;
      out_popped_q <= popped_q;
      out_count_q  <= COUNT_W'(count_q);
      out_full_q   <= is_full;
      out_empty_q  <= (count_q == '0);
      out_under_q  <= under_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.average      = out_avg_q;
  assign out_o.popped_value = out_popped_q;
  assign out_o.count        = out_count_q;
  assign out_o.is_full      = out_full_q;
  assign out_o.is_empty     = out_empty_q;
  assign out_o.underflow    = out_under_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside divide state");

  a_under_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && op_q == OP_POP && count_q == '0)
      |=> count_q == '0 && $stable(oldest_q) && $stable(sum_q))
    else $error("pop on empty ring changed state");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && out_valid_q |-> out_o.ready)
    else $error("result register overwritten while stalled");

endmodule
